/* rtl/xcrc_pkg.sv */
// xcrc_pkg: shared types, protocol bytes, command/status/register codes
// and the crc-16 step for the xmodem-crc receiver; no dependencies
package xcrc_pkg;

	localparam int PacketBytes = 128;
	localparam int IdxW = $clog2(PacketBytes);

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_ABORT    = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	localparam logic [0:0] REG_MAX_LENGTH = 1'd0;
	localparam logic [0:0] REG_WAIT_TICKS = 1'd1;

	typedef struct packed {
		logic clear;
		logic update;
	} crc_ctl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* rtl/xcrc_crc16.sv */
// xcrc_crc16: running crc-16/xmodem register, one byte per cycle
// depends on xcrc_pkg
module xcrc_crc16 (
	input  logic                clk,
	input  logic                arst_n,
	input  xcrc_pkg::crc_ctl_t  ctl,
	input  logic [7:0]          data,
	output logic [15:0]         crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.clear) begin
			crc_q <= '0;
		end else if (ctl.update) begin
			crc_q <= xcrc_pkg::crc_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

/* rtl/xmodem_crc_receiver_core.sv */
// xmodem_crc_receiver_core: xmodem-crc receiver, 128-byte packets, top level
// depends on xcrc_pkg and xcrc_crc16
//
// One word is taken per clock cycle: each accepted command word (start, byte,
// tick, no-op) is decoded and its state update done in the cycle it is
// accepted, and its result word is held in a single output register. The
// input is ready whenever that register is empty or being drained, so a
// sustained rate of one word per cycle holds while results are taken. The
// byte-wide crc update and the 32-bit silence compare set the cycle path.
// Configuration writes take effect at once; no clearing pass after reset.
module xmodem_crc_receiver_core #(
	parameter int START_RETRIES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic        finished,
	output logic [1:0]  status,
	output logic [23:0] byte_count
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SYNC   = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_SEQ    = 3'd3;
	localparam logic [2:0] PH_SEQINV = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_CRCHI  = 3'd6;
	localparam logic [2:0] PH_CRCLO  = 3'd7;

	localparam int IW = xcrc_pkg::IdxW;
	localparam logic [IW-1:0] LAST_IDX = IW'(xcrc_pkg::PacketBytes - 1);
	// packet count saturates once its byte total exceeds any max_length
	localparam int PW = 24 - IW + 1;
	localparam logic [2:0] RETRIES = 3'(START_RETRIES);

	logic [23:0]   max_len_q;
	logic [31:0]   wait_q;
	logic [2:0]    phase_q, phase_d;
	logic [7:0]    exp_seq_q, exp_seq_d;
	logic [7:0]    seq_q, seq_d;
	logic [7:0]    seqinv_q, seqinv_d;
	logic [7:0]    crchi_q, crchi_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [23:0]   left_q, left_d;
	logic [PW-1:0] pkt_q, pkt_d;
	logic [31:0]   silent_q, silent_d;
	logic [2:0]    attempts_q, attempts_d;

	logic          res_valid_q;
	logic          tx_valid_q, data_valid_q, finished_q;
	logic [7:0]    tx_byte_q, data_byte_q;
	logic [1:0]    status_q;
	logic [23:0]   byte_count_q;

	logic          r_tx, r_data, r_fin;
	logic [7:0]    r_tx_byte, r_data_byte;
	logic [1:0]    r_status;
	logic [23:0]   r_count;

	logic          accept;
	logic [31:0]   silent_inc;
	logic [24:0]   bytes_done;
	logic [15:0]   crc;
	xcrc_pkg::crc_ctl_t crc_ctl;

	assign item_ready = !res_valid_q || result_ready;
	assign accept = item_valid && item_ready;
	assign bytes_done = {pkt_q, {IW{1'b0}}};
	assign silent_inc = (silent_q == '1) ? silent_q : silent_q + 32'd1;

	xcrc_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (rx_byte),
		.crc    (crc)
	);

	always_comb begin
		phase_d = phase_q;
		exp_seq_d = exp_seq_q;
		seq_d = seq_q;
		seqinv_d = seqinv_q;
		crchi_d = crchi_q;
		idx_d = idx_q;
		left_d = left_q;
		pkt_d = pkt_q;
		silent_d = silent_q;
		attempts_d = attempts_q;
		crc_ctl = '0;
		r_tx = 1'b0;
		r_tx_byte = '0;
		r_data = 1'b0;
		r_data_byte = '0;
		r_fin = 1'b0;
		r_status = xcrc_pkg::ST_NONE;
		r_count = '0;
		case (command)
			xcrc_pkg::CMD_START: begin
				phase_d = PH_SYNC;
				exp_seq_d = 8'd1;
				seq_d = '0;
				seqinv_d = '0;
				crchi_d = '0;
				idx_d = '0;
				left_d = max_len_q;
				pkt_d = '0;
				silent_d = '0;
				attempts_d = '0;
				crc_ctl.clear = 1'b1;
				r_tx = 1'b1;
				r_tx_byte = xcrc_pkg::B_C;
			end
			xcrc_pkg::CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					silent_d = silent_inc;
					if (silent_inc >= wait_q) begin
						silent_d = '0;
						if (phase_q == PH_SYNC && attempts_q < RETRIES) begin
							attempts_d = attempts_q + 3'd1;
							r_tx = 1'b1;
							r_tx_byte = xcrc_pkg::B_C;
						end else begin
							r_fin = 1'b1;
							r_status = xcrc_pkg::ST_TIMEOUT;
							phase_d = PH_IDLE;
						end
					end
				end
			end
			xcrc_pkg::CMD_BYTE: begin
				if (phase_q != PH_IDLE) begin
					silent_d = '0;
					case (phase_q)
						PH_SYNC, PH_HEADER: begin
							if (rx_byte == xcrc_pkg::B_SOH) begin
								phase_d = PH_SEQ;
								crc_ctl.clear = 1'b1;
								idx_d = '0;
							end else if (rx_byte == xcrc_pkg::B_EOT) begin
								r_tx = 1'b1;
								r_tx_byte = xcrc_pkg::B_ACK;
								r_fin = 1'b1;
								r_status = xcrc_pkg::ST_COMPLETE;
								r_count = (bytes_done < {1'b0, max_len_q}) ?
									bytes_done[23:0] : max_len_q;
								phase_d = PH_IDLE;
							end else begin
								r_fin = 1'b1;
								r_status = xcrc_pkg::ST_ABORT;
								phase_d = PH_IDLE;
							end
						end
						PH_SEQ: begin
							seq_d = rx_byte;
							phase_d = PH_SEQINV;
						end
						PH_SEQINV: begin
							seqinv_d = rx_byte;
							phase_d = PH_DATA;
						end
						PH_DATA: begin
							crc_ctl.update = 1'b1;
							if (left_q != '0) begin
								r_data = 1'b1;
								r_data_byte = rx_byte;
								left_d = left_q - 24'd1;
							end
							if (idx_q == LAST_IDX) begin
								idx_d = '0;
								phase_d = PH_CRCHI;
							end else begin
								idx_d = idx_q + 1'b1;
							end
						end
						PH_CRCHI: begin
							crchi_d = rx_byte;
							phase_d = PH_CRCLO;
						end
						PH_CRCLO: begin
							if ({crchi_q, rx_byte} == crc && seq_q == exp_seq_q &&
								seqinv_q == ~exp_seq_q) begin
								r_tx = 1'b1;
								r_tx_byte = xcrc_pkg::B_ACK;
								exp_seq_d = exp_seq_q + 8'd1;
								if (!pkt_q[PW-1]) begin
									pkt_d = pkt_q + 1'b1;
								end
								phase_d = PH_HEADER;
							end else begin
								r_tx = 1'b1;
								r_tx_byte = xcrc_pkg::B_CAN;
								r_fin = 1'b1;
								r_status = xcrc_pkg::ST_ABORT;
								phase_d = PH_IDLE;
							end
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			crc_ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 24'hffffff;
			wait_q <= 32'd1000000;
		end else if (cfg_we) begin
			case (cfg_index)
				xcrc_pkg::REG_MAX_LENGTH: max_len_q <= cfg_data[23:0];
				xcrc_pkg::REG_WAIT_TICKS: wait_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			exp_seq_q <= 8'd1;
			seq_q <= '0;
			seqinv_q <= '0;
			crchi_q <= '0;
			idx_q <= '0;
			left_q <= '0;
			pkt_q <= '0;
			silent_q <= '0;
			attempts_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			exp_seq_q <= exp_seq_d;
			seq_q <= seq_d;
			seqinv_q <= seqinv_d;
			crchi_q <= crchi_d;
			idx_q <= idx_d;
			left_q <= left_d;
			pkt_q <= pkt_d;
			silent_q <= silent_d;
			attempts_q <= attempts_d;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_valid_q <= r_tx;
			tx_byte_q <= r_tx_byte;
			data_valid_q <= r_data;
			data_byte_q <= r_data_byte;
			finished_q <= r_fin;
			status_q <= r_status;
			byte_count_q <= r_count;
		end
	end

	assign result_valid = res_valid_q;
	assign tx_valid = tx_valid_q;
	assign tx_byte = tx_byte_q;
	assign data_valid = data_valid_q;
	assign data_byte = data_byte_q;
	assign finished = finished_q;
	assign status = status_q;
	assign byte_count = byte_count_q;

endmodule

/* test/testbench.sv */
// testbench for xmodem_crc_receiver_core: drives start, byte, tick and no-op words,
// predicts every reply word with an in-line receiver model and checks it field by field
// depends on xcrc_pkg and the receiver rtl
`timescale 1ns / 1ps

module testbench;
	import xcrc_pkg::*;

	localparam int RetryLimit = 3;
	localparam logic [1:0] CMD_NOOP = 2'd3;
	localparam logic [7:0] B_ESC = 8'h1b;

	typedef enum logic [3:0] {
		RX_IDLE, RX_SYNC, RX_HEADER, RX_SEQ, RX_SEQINV, RX_DATA, RX_CRCHI, RX_CRCLO
	} rx_phase_e;

	typedef enum int {
		PKT_GOOD, PKT_BAD_CRC, PKT_BAD_SEQ, PKT_BAD_INV, PKT_STALL, PKT_CUT
	} pkt_kind_e;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
	} word_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        finished;
		logic [1:0]  status;
		logic [23:0] byte_count;
	} reply_t;

	typedef struct {
		reply_t fields;
		time    taken_at;
	} awaited_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_MAX_LENGTH;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  command = CMD_NOOP;
	logic [7:0]  rx_byte = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic        finished;
	logic [1:0]  status;
	logic [23:0] byte_count;

	word_t          pending_words[$];
	awaited_reply_t awaited[$];
	int             tx_gap_pct = 0;
	int             rx_gap_pct = 0;
	int             mismatches = 0;
	int             words_queued = 0;

	// receiver model state and its copy of the registers
	logic [23:0] cfg_max_len = 24'hFF_FFFF;
	logic [31:0] cfg_wait = 32'd1000000;
	rx_phase_e   rx_phase = RX_IDLE;
	logic [7:0]  want_seq = 8'd1;
	logic [7:0]  seq_got = '0;
	logic [7:0]  seq_inv_got = '0;
	logic [15:0] crc_acc = '0;
	logic [7:0]  crc_hi_got = '0;
	logic [6:0]  data_idx = '0;
	logic [23:0] bytes_left = '0;
	logic [31:0] total_bytes = '0;
	logic [31:0] quiet_ticks = '0;
	logic [2:0]  retries = '0;

	xmodem_crc_receiver_core #(.START_RETRIES(RetryLimit)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.command(command), .rx_byte(rx_byte),
		.result_valid(result_valid), .result_ready(result_ready),
		.tx_valid(tx_valid), .tx_byte(tx_byte),
		.data_valid(data_valid), .data_byte(data_byte),
		.finished(finished), .status(status), .byte_count(byte_count)
	);

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ 16'h1021;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic reply_t predict_reply(input logic [1:0] cmd, input logic [7:0] b);
		reply_t r;
		r = '0;
		case (cmd)
			CMD_START: begin
				rx_phase = RX_SYNC;
				want_seq = 8'd1;
				seq_got = '0;
				seq_inv_got = '0;
				crc_acc = '0;
				crc_hi_got = '0;
				data_idx = '0;
				bytes_left = cfg_max_len;
				total_bytes = '0;
				quiet_ticks = '0;
				retries = '0;
				r.tx_valid = 1'b1;
				r.tx_byte = B_C;
			end
			CMD_TICK: begin
				if (rx_phase != RX_IDLE) begin
					if (quiet_ticks != 32'hFFFF_FFFF)
						quiet_ticks++;
					if (quiet_ticks >= cfg_wait) begin
						quiet_ticks = '0;
						if (rx_phase == RX_SYNC && retries < RetryLimit) begin
							retries++;
							r.tx_valid = 1'b1;
							r.tx_byte = B_C;
						end else begin
							r.finished = 1'b1;
							r.status = ST_TIMEOUT;
							rx_phase = RX_IDLE;
						end
					end
				end
			end
			CMD_BYTE: begin
				if (rx_phase != RX_IDLE) begin
					quiet_ticks = '0;
					case (rx_phase)
						RX_SYNC, RX_HEADER: begin
							if (b == B_SOH) begin
								rx_phase = RX_SEQ;
								crc_acc = '0;
								data_idx = '0;
							end else if (b == B_EOT) begin
								r.tx_valid = 1'b1;
								r.tx_byte = B_ACK;
								r.finished = 1'b1;
								r.status = ST_COMPLETE;
								r.byte_count = (total_bytes < {8'd0, cfg_max_len}) ?
									total_bytes[23:0] : cfg_max_len;
								rx_phase = RX_IDLE;
							end else begin
								r.finished = 1'b1;
								r.status = ST_ABORT;
								rx_phase = RX_IDLE;
							end
						end
						RX_SEQ: begin
							seq_got = b;
							rx_phase = RX_SEQINV;
						end
						RX_SEQINV: begin
							seq_inv_got = b;
							rx_phase = RX_DATA;
						end
						RX_DATA: begin
							crc_acc = crc16_step(crc_acc, b);
							if (bytes_left != 0) begin
								r.data_valid = 1'b1;
								r.data_byte = b;
								bytes_left--;
							end
							if (data_idx == 7'(PacketBytes - 1)) begin
								data_idx = '0;
								rx_phase = RX_CRCHI;
							end else begin
								data_idx++;
							end
						end
						RX_CRCHI: begin
							crc_hi_got = b;
							rx_phase = RX_CRCLO;
						end
						default: begin
							r.tx_valid = 1'b1;
							if ({crc_hi_got, b} == crc_acc && seq_got == want_seq &&
									seq_inv_got == ~want_seq) begin
								r.tx_byte = B_ACK;
								want_seq++;
								if (total_bytes > 32'hFFFF_FFFF - PacketBytes)
									total_bytes = 32'hFFFF_FFFF;
								else
									total_bytes += PacketBytes;
								rx_phase = RX_HEADER;
							end else begin
								r.tx_byte = B_CAN;
								r.finished = 1'b1;
								r.status = ST_ABORT;
								rx_phase = RX_IDLE;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic int silence_window();
		return (cfg_wait == 0) ? 1 : int'(cfg_wait);
	endfunction

	task automatic queue_word(input logic [1:0] cmd, input logic [7:0] b);
		word_t w;
		w.cmd = cmd;
		w.data = b;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_word(CMD_TICK, 8'($urandom));
	endtask

	// ticks that stay short of the window, plus the odd no-op
	task automatic queue_gap_noise();
		int most;
		if (cfg_wait >= 2 && $urandom_range(99) < 8) begin
			most = (cfg_wait - 1 < 3) ? int'(cfg_wait - 1) : 3;
			queue_ticks($urandom_range(1, most));
		end
		if ($urandom_range(99) < 3)
			queue_word(CMD_NOOP, 8'($urandom));
	endtask

	task automatic queue_packet(input logic [7:0] seq, input pkt_kind_e kind);
		logic [15:0] crc;
		logic [15:0] crc_sent;
		logic [7:0]  b;
		logic [7:0]  flip;
		int          cut_at;
		crc = '0;
		crc_sent = '0;
		cut_at = $urandom_range(0, PacketBytes + 4);
		flip = 8'($urandom_range(1, 255));
		for (int pos = 0; pos < PacketBytes + 5; pos++) begin
			if (kind == PKT_CUT && pos == cut_at)
				return;
			if (kind == PKT_STALL && pos == cut_at) begin
				queue_ticks(silence_window());
				return;
			end
			if (pos == 0) begin
				b = B_SOH;
			end else if (pos == 1) begin
				b = (kind == PKT_BAD_SEQ) ? seq ^ flip : seq;
			end else if (pos == 2) begin
				b = (kind == PKT_BAD_INV) ? ~seq ^ flip : ~seq;
			end else if (pos < PacketBytes + 3) begin
				b = 8'($urandom);
				crc = crc16_step(crc, b);
			end else if (pos == PacketBytes + 3) begin
				crc_sent = (kind == PKT_BAD_CRC) ? crc ^ 16'($urandom_range(1, 65535)) : crc;
				b = crc_sent[15:8];
			end else begin
				b = crc_sent[7:0];
			end
			queue_gap_noise();
			queue_word(CMD_BYTE, b);
		end
	endtask

	task automatic queue_transfer(output bit left_open);
		int          k;
		int          roll;
		int          packets;
		logic [7:0]  seq;
		logic [7:0]  hdr;
		pkt_kind_e   kind;
		left_open = 1'b0;
		queue_word(CMD_START, 8'($urandom));
		if (cfg_wait <= 20 && $urandom_range(99) < 30) begin
			k = $urandom_range(1, RetryLimit + 1);
			queue_ticks(k * silence_window());
			if (k > RetryLimit)
				return;
		end
		packets = $urandom_range(0, 3);
		seq = 8'd1;
		for (int p = 0; p < packets; p++) begin
			roll = $urandom_range(99);
			if (roll < 78)
				kind = PKT_GOOD;
			else if (roll < 83)
				kind = PKT_BAD_CRC;
			else if (roll < 87)
				kind = PKT_BAD_SEQ;
			else if (roll < 91)
				kind = PKT_BAD_INV;
			else if (roll < 95)
				kind = (cfg_wait <= 20) ? PKT_STALL : PKT_GOOD;
			else
				kind = PKT_CUT;
			queue_packet(seq, kind);
			if (kind == PKT_CUT) begin
				left_open = 1'b1;
				return;
			end
			if (kind != PKT_GOOD)
				return;
			seq++;
		end
		queue_gap_noise();
		roll = $urandom_range(99);
		if (roll < 4 && cfg_wait <= 20) begin
			queue_ticks(silence_window());
			return;
		end
		if (roll < 84)
			hdr = B_EOT;
		else if (roll < 88)
			hdr = B_CAN;
		else if (roll < 92)
			hdr = B_ESC;
		else if (roll < 96) begin
			do
				hdr = 8'($urandom);
			while (hdr == B_SOH || hdr == B_EOT);
		end else begin
			left_open = 1'b1;
			return;
		end
		queue_word(CMD_BYTE, hdr);
		// words after the end of a transfer are ignored
		if ($urandom_range(99) < 15) begin
			k = $urandom_range(1, 3);
			for (int i = 0; i < k; i++)
				queue_word(2'($urandom_range(1, 3)), 8'($urandom));
		end
	endtask

	task automatic queue_random_phase(input int n);
		int target;
		bit open_end;
		target = words_queued + n;
		@(negedge clk);
		do
			queue_transfer(open_end);
		while (words_queued < target || open_end);
	endtask

	task automatic write_regs(input logic [23:0] len, input logic [31:0] ticks);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_LENGTH;
		cfg_data <= {8'($urandom), len};
		@(posedge clk);
		cfg_index <= REG_WAIT_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_max_len = len;
		cfg_wait = ticks;
	endtask

	task automatic wait_until_settled();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || item_valid || awaited.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_gaps(input int tx_pct, input int rx_pct);
		@(negedge clk);
		tx_gap_pct = tx_pct;
		rx_gap_pct = rx_pct;
	endtask

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// driver: one word from the pending queue, held until accepted
	always @(posedge clk) begin
		word_t          next_word;
		awaited_reply_t entry;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				entry.fields = predict_reply(command, rx_byte);
				entry.taken_at = $time;
				awaited.push_back(entry);
			end
			if (!item_valid || item_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
					next_word = pending_words.pop_front();
					item_valid <= 1'b1;
					command <= next_word.cmd;
					rx_byte <= next_word.data;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each reply word against the oldest prediction
	always @(posedge clk) begin
		awaited_reply_t head;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (awaited.size() == 0 || awaited[0].taken_at == $time) begin
					$display("%0t ns: reply expected none, got %h", $time,
						{tx_valid, tx_byte, data_valid, data_byte, finished, status, byte_count});
					mismatches++;
				end else begin
					head = awaited.pop_front();
					compare_field("tx_valid", head.fields.tx_valid, tx_valid);
					compare_field("tx_byte", head.fields.tx_byte, tx_byte);
					compare_field("data_valid", head.fields.data_valid, data_valid);
					compare_field("data_byte", head.fields.data_byte, data_byte);
					compare_field("finished", head.fields.finished, finished);
					compare_field("status", head.fields.status, status);
					compare_field("byte_count", head.fields.byte_count, byte_count);
				end
			end
			result_ready <= $urandom_range(99) >= rx_gap_pct;
		end
	end

	initial begin
		tx_gap_pct = 17;
		rx_gap_pct = 74;
		// idle words, then the header cases with the reset settings
		queue_word(CMD_NOOP, 8'h00);
		queue_word(CMD_TICK, 8'hFF);
		queue_word(CMD_BYTE, 8'hFF);
		queue_word(CMD_START, 8'hFF);
		queue_word(CMD_NOOP, 8'hAA);
		queue_word(CMD_BYTE, B_EOT);
		queue_word(CMD_START, 8'h00);
		queue_word(CMD_BYTE, B_CAN);
		queue_word(CMD_START, 8'h55);
		queue_word(CMD_BYTE, B_ESC);
		queue_word(CMD_START, 8'h00);
		queue_word(CMD_START, 8'h00);
		queue_word(CMD_BYTE, 8'h00);
		queue_word(CMD_START, 8'h00);
		queue_word(CMD_BYTE, 8'hFF);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait_until_settled();

		// zero window: every tick ends a window, retries then timeout
		write_regs(24'd0, 32'd0);
		@(negedge clk);
		queue_word(CMD_START, 8'h00);
		queue_ticks(RetryLimit + 1);
		queue_word(CMD_START, 8'h00);
		queue_word(CMD_BYTE, B_SOH);
		queue_word(CMD_TICK, 8'h00);
		wait_until_settled();

		write_regs(24'hFF_FFFF, 32'd4);
		queue_random_phase(100);
		wait_until_settled();
		write_regs(24'd0, 32'd1);
		queue_random_phase(100);
		wait_until_settled();

		set_gaps(74, 17);
		write_regs(24'd150, 32'hFFFF_FFFF);
		queue_random_phase(100);
		wait_until_settled();
		write_regs(24'd100, 32'd0);
		queue_random_phase(100);
		wait_until_settled();

		set_gaps(0, 0);
		write_regs(24'($urandom_range(1, 400)), 32'($urandom_range(2, 20)));
		queue_random_phase(100);
		wait_until_settled();
		write_regs(24'hFF_FFFF, 32'd1000000);
		queue_random_phase(100);
		wait_until_settled();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("xmodem_crc_receiver_core verification clean");
		else
			$display("xmodem_crc_receiver_core verification failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("xmodem_crc_receiver_core verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/xcrc_pkg.sv
rtl/xcrc_crc16.sv
rtl/xmodem_crc_receiver_core.sv
test/testbench.sv
